>>> rtl/mhfp_pkg.sv
package mhfp_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NAME_IDX_W = 5;
  localparam int unsigned NAME_BYTES = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_HIGH  = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_MARKER   = 2'd1;
  localparam logic [1:0] ERR_MISMATCH = 2'd2;
  localparam logic [1:0] ERR_COLON    = 2'd3;

  typedef struct packed {
    logic       start_req;
    logic [7:0] text_char;
  } in_item_t;

  typedef struct packed {
    logic        value_valid;
    logic [7:0]  value_char;
    logic        done_res;
    logic [1:0]  error_code;
    logic [15:0] error_line;
    logic [15:0] error_column;
  } out_item_t;

  typedef struct packed {
    logic                           mode;
    logic [NAME_IDX_W-1:0]          name_len_eff;
    logic [NAME_BYTES-1:0][7:0]     name_bytes;
  } cfg_t;

endpackage

>>> rtl/mhfp_cfg.sv
module mhfp_cfg
  import mhfp_pkg::*;
#(
  parameter int unsigned NAME_MAX = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic                  mode_q;
  logic [NAME_IDX_W-1:0] name_len_q;
  logic [63:0]           name_low_q;
  logic [63:0]           name_high_q;
  logic [NAME_IDX_W-1:0] len_clip;
  logic [NAME_IDX_W-1:0] len_eff;
  logic [NAME_BYTES-1:0][7:0] bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      name_len_q  <= '0;
      name_low_q  <= '0;
      name_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:      mode_q      <= cfg_data_i[0];
        CFG_NAME_LEN:  name_len_q  <= cfg_data_i[NAME_IDX_W-1:0];
        CFG_NAME_LOW:  name_low_q  <= cfg_data_i[63:0];
        CFG_NAME_HIGH: name_high_q <= cfg_data_i[63:0];
        default: ;
      endcase
    end
  end

  assign bytes = {name_high_q, name_low_q};

  // clip to the name store, then stop at the first zero byte
  always_comb begin
    len_clip = (name_len_q > NAME_IDX_W'(NAME_MAX)) ? NAME_IDX_W'(NAME_MAX) : name_len_q;
    len_eff  = len_clip;
    for (int i = NAME_MAX - 1; i >= 0; i--) begin
      if ((NAME_IDX_W'(i) < len_clip) && (bytes[i] == 8'h00)) begin
        len_eff = NAME_IDX_W'(i);
      end
    end
  end

  assign cfg_o.mode         = mode_q;
  assign cfg_o.name_len_eff = len_eff;
  assign cfg_o.name_bytes   = bytes;

endmodule

>>> rtl/mhfp_step.sv
module mhfp_step
  import mhfp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEAD     = 3'd1,
    PH_PRENAME  = 3'd2,
    PH_NAME     = 3'd3,
    PH_POSTNAME = 3'd4,
    PH_PREVALUE = 3'd5,
    PH_VALUE    = 3'd6
  } phase_e;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] line_q, line_d;
  logic [COUNT_WIDTH-1:0] col_q, col_d;
  logic [NAME_IDX_W-1:0]  idx_q, idx_d;
  logic [COUNT_WIDTH-1:0] nsc_q, nsc_d;

  logic [7:0] c;
  logic       blank;
  logic       space;
  logic       take;
  logic [7:0] marker;
  out_item_t  res;

  function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  assign c      = item_i.text_char;
  assign blank  = (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
  assign space  = blank || (c == CHAR_LF) || (c == CHAR_CR);
  assign marker = cfg_i.mode ? CHAR_DASH : CHAR_HASH;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    nsc_d   = nsc_q;
    line_d  = line_q;
    col_d   = col_q;
    take    = 1'b0;
    res     = '0;

    if (item_i.start_req) phase_d = PH_LEAD;
    // phases that pass the character on without consuming it
    if (phase_d == PH_PRENAME && !blank) begin
      idx_d   = '0;
      nsc_d   = col_q;
      phase_d = PH_NAME;
    end
    if (phase_d == PH_NAME && ((idx_d >= cfg_i.name_len_eff) || (c == CHAR_NUL))) begin
      phase_d = PH_POSTNAME;
    end
    if (phase_d == PH_PREVALUE && !blank) phase_d = PH_VALUE;

    unique case (phase_d)
      PH_IDLE: ;
      PH_LEAD: begin
        if (c != CHAR_NUL && space) begin
          take = 1'b1;
        end else if (c == marker) begin
          take    = 1'b1;
          phase_d = cfg_i.mode ? PH_PRENAME : PH_PREVALUE;
        end else begin
          res.done_res     = 1'b1;
          res.error_code   = ERR_MARKER;
          res.error_line   = sat16(line_q);
          res.error_column = sat16(col_q);
          phase_d          = PH_IDLE;
        end
      end
      PH_PRENAME: take = 1'b1;
      PH_NAME: begin
        if (c == cfg_i.name_bytes[idx_d[3:0]]) begin
          take  = 1'b1;
          idx_d = idx_d + NAME_IDX_W'(1);
          if (idx_d >= cfg_i.name_len_eff) phase_d = PH_POSTNAME;
        end else begin
          res.done_res     = 1'b1;
          res.error_code   = ERR_MISMATCH;
          res.error_line   = sat16(line_q);
          res.error_column = sat16(nsc_d);
          phase_d          = PH_IDLE;
        end
      end
      PH_POSTNAME: begin
        if (blank) begin
          take = 1'b1;
        end else if (c == CHAR_COLON) begin
          take    = 1'b1;
          phase_d = PH_PREVALUE;
        end else begin
          res.done_res     = 1'b1;
          res.error_code   = ERR_COLON;
          res.error_line   = sat16(line_q);
          res.error_column = sat16(col_q);
          phase_d          = PH_IDLE;
        end
      end
      PH_PREVALUE: take = 1'b1;
      PH_VALUE: begin
        if (c == CHAR_NUL) begin
          res.done_res = 1'b1;
          phase_d      = PH_IDLE;
        end else if (c == CHAR_LF) begin
          take         = 1'b1;
          res.done_res = 1'b1;
          phase_d      = PH_IDLE;
        end else begin
          take            = 1'b1;
          res.value_valid = 1'b1;
          res.value_char  = c;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    // position update for a consumed character
    if (take) begin
      if (c == CHAR_LF) begin
        if (line_q != CNT_MAX) line_d = line_q + CNT_ONE;
        col_d = CNT_ONE;
      end else if (col_q != CNT_MAX) begin
        col_d = col_q + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      line_q  <= CNT_ONE;
      col_q   <= CNT_ONE;
      idx_q   <= '0;
      nsc_q   <= CNT_ONE;
    end else if (adv_i) begin
      phase_q <= phase_d;
      line_q  <= line_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      nsc_q   <= nsc_d;
    end
  end

  assign res_o = res;

endmodule

>>> rtl/markdown_header_field_parser.sv
// markdown header field parser
// in channel: one text character per item (in_valid_i/in_ready_o, in_item_i);
//   start_req restarts extraction at this character, otherwise the running
//   extraction continues; with no extraction running the item gives an
//   all-zero result
// out channel: exactly one result per input item, in order
//   (out_valid_o/out_ready_i, out_item_o): a value character, a done flag
//   with error code and location, or nothing
// config port: cfg_we_i, cfg_index_i, cfg_data_i, write only;
//   0 mode, 1 name length, 2 name chars 0-7, 3 name chars 8-15
// order: an item lands in the input register, then its result is computed
//   by the phase logic and stored in the output register once that is free,
//   which raises out_valid_o
// throughput: one item per cycle unless a result is held; the phase and
//   position registers update in the same cycle a result is registered
// reset: no items held, phase idle, line and column back to one, config
//   registers zero
// stall: a held result stops the phase logic, the input register keeps
//   one more item, then in_ready_o drops until the result is taken
module markdown_header_field_parser
  import mhfp_pkg::*;
#(
  parameter int unsigned NAME_MAX    = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  logic      adv;
  cfg_t      cfg;
  out_item_t res;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  mhfp_cfg #(
    .NAME_MAX (NAME_MAX)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mhfp_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_item_q <= in_item_i;
    if (adv) out_item_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("result not registered after advance");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a full pipe");

  a_value_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_item_q.value_valid && out_item_q.done_res))
    else $error("value and done in one result");

  a_error_has_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_item_q.error_code != ERR_OK) |->
      (out_item_q.done_res && out_item_q.error_line != 16'h0000 &&
       out_item_q.error_column != 16'h0000))
    else $error("error reported without done or location");
`endif

endmodule

>>> sim/markdown_header_field_parser_tb.sv
module markdown_header_field_parser_tb
  import mhfp_pkg::*;
;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [15:0] POS_MAX = 16'hFFFF;
  localparam int NAME_LIMIT = 16;
  localparam int SEG_ITEMS = 50;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_PRENAME, PH_NAME, PH_POSTNAME, PH_PREVALUE, PH_VALUE
  } parse_phase_e;

  class header_field_model;
    logic        mode;
    logic [4:0]  name_len;
    logic [63:0] chars_lo;
    logic [63:0] chars_hi;
    parse_phase_e ph;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [4:0]  name_pos;
    logic [15:0] name_col;
    out_item_t   pending_results[$];
    int          errors;

    function new();
      mode = 1'b0;
      name_len = '0;
      chars_lo = '0;
      chars_hi = '0;
      ph = PH_IDLE;
      line_no = 16'd1;
      col_no = 16'd1;
      name_pos = '0;
      name_col = 16'd1;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:      mode = data[0];
        CFG_NAME_LEN:  name_len = data[4:0];
        CFG_NAME_LOW:  chars_lo = data;
        CFG_NAME_HIGH: chars_hi = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] name_char(int idx);
      if (idx < 8) return chars_lo[8*idx +: 8];
      if (idx < 16) return chars_hi[8*(idx-8) +: 8];
      return CH_NUL;
    endfunction

    function int eff_len();
      int n;
      n = name_len;
      if (n > NAME_LIMIT) n = NAME_LIMIT;
      for (int i = 0; i < n; i++) begin
        if (name_char(i) == CH_NUL) return i;
      end
      return n;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

    function void advance(logic [7:0] c);
      if (c == CH_LF) begin
        if (line_no != POS_MAX) line_no++;
        col_no = 16'd1;
      end else if (col_no != POS_MAX) begin
        col_no++;
      end
    endfunction

    function void consume_char(in_item_t it);
      out_item_t r;
      logic [7:0] c;
      bit again;
      r = '0;
      c = it.text_char;
      if (it.start_req) ph = PH_LEAD;
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        case (ph)
          PH_LEAD: begin
            if (c != CH_NUL && (is_blank(c) || c == CH_LF || c == CH_CR)) begin
              advance(c);
            end else if (c == (mode ? CH_DASH : CH_HASH)) begin
              advance(c);
              if (mode) ph = PH_PRENAME;
              else ph = PH_PREVALUE;
            end else begin
              r.done_res = 1'b1;
              r.error_code = ERR_MARKER;
              r.error_line = line_no;
              r.error_column = col_no;
              ph = PH_IDLE;
            end
          end
          PH_PRENAME: begin
            if (is_blank(c)) begin
              advance(c);
            end else begin
              name_pos = '0;
              name_col = col_no;
              ph = PH_NAME;
              again = 1'b1;
            end
          end
          PH_NAME: begin
            if (name_pos >= eff_len() || c == CH_NUL) begin
              ph = PH_POSTNAME;
              again = 1'b1;
            end else if (c == name_char(name_pos)) begin
              advance(c);
              name_pos = name_pos + 5'd1;
              if (name_pos >= eff_len()) ph = PH_POSTNAME;
            end else begin
              r.done_res = 1'b1;
              r.error_code = ERR_MISMATCH;
              r.error_line = line_no;
              r.error_column = name_col;
              ph = PH_IDLE;
            end
          end
          PH_POSTNAME: begin
            if (is_blank(c)) begin
              advance(c);
            end else if (c == CH_COLON) begin
              advance(c);
              ph = PH_PREVALUE;
            end else begin
              r.done_res = 1'b1;
              r.error_code = ERR_COLON;
              r.error_line = line_no;
              r.error_column = col_no;
              ph = PH_IDLE;
            end
          end
          PH_PREVALUE: begin
            if (is_blank(c)) begin
              advance(c);
            end else begin
              ph = PH_VALUE;
              again = 1'b1;
            end
          end
          PH_VALUE: begin
            if (c == CH_NUL) begin
              r.done_res = 1'b1;
              ph = PH_IDLE;
            end else if (c == CH_LF) begin
              advance(c);
              r.done_res = 1'b1;
              ph = PH_IDLE;
            end else begin
              advance(c);
              r.value_valid = 1'b1;
              r.value_char = c;
            end
          end
          default: ph = PH_IDLE;
        endcase
      end
      pending_results.push_back(r);
    endfunction

    function void cmp_field(string fname, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", fname, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with no pending expectation");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      cmp_field("value_valid", 16'(want.value_valid), 16'(got.value_valid));
      cmp_field("value_char", 16'(want.value_char), 16'(got.value_char));
      cmp_field("done_res", 16'(want.done_res), 16'(got.done_res));
      cmp_field("error_code", 16'(want.error_code), 16'(got.error_code));
      cmp_field("error_line", want.error_line, got.error_line);
      cmp_field("error_column", want.error_column, got.error_column);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  header_field_model book;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [7:0] line_q[$];

  markdown_header_field_parser uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) book.check_result(out_item_o);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic st, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{start_req: st, text_char: ch};
    do @(posedge clk_i); while (!in_ready_o);
    book.consume_char('{start_req: st, text_char: ch});
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(i == 0, s[i]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic m, input logic [4:0] len,
                           input logic [63:0] lo, input logic [63:0] hi);
    logic [CFG_IDX_W-1:0] idx_list[4];
    logic [CFG_DATA_W-1:0] data_list[4];
    idx_list = '{CFG_MODE, CFG_NAME_LEN, CFG_NAME_LOW, CFG_NAME_HIGH};
    data_list = '{{63'd0, m}, {59'd0, len}, lo, hi};
    for (int r = 0; r < 4; r++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx_list[r];
      cfg_data_i <= data_list[r];
      @(negedge clk_i);
      book.set_reg(idx_list[r], data_list[r]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_name(int lo_c, int hi_c);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'($urandom_range(lo_c, hi_c));
    return v;
  endfunction

  task automatic apply_setting(input int k);
    logic [63:0] lo;
    case (k)
      0: write_cfg(1'b0, 5'd0, '0, '0);
      1: write_cfg(1'b1, 5'd5, 64'h0000_0065_6c74_6974, '0);
      2: write_cfg(1'b1, 5'd16, rand_name(33, 126), rand_name(33, 126));
      3: write_cfg(1'b1, 5'd0, rand_name(33, 126), rand_name(33, 126));
      4: write_cfg(1'b1, 5'd31, '1, '1);
      5: begin
        lo = rand_name(33, 126);
        lo[31:24] = CH_NUL;
        write_cfg(1'b1, 5'd10, lo, rand_name(33, 126));
      end
      6: write_cfg(1'b1, 5'($urandom_range(1, 16)), rand_name(1, 255), rand_name(1, 255));
      default: write_cfg(1'b0, 5'($urandom_range(0, 31)), {$urandom, $urandom},
                         {$urandom, $urandom});
    endcase
  endtask

  task automatic set_idling(input int m);
    case (m)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 67; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 67; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] pick_lead();
    case ($urandom_range(5))
      0: return CH_LF;
      1: return CH_CR;
      default: return pick_blank();
    endcase
  endfunction

  task automatic build_line(input int kind);
    logic [7:0] c;
    int pos;
    line_q.delete();
    if (kind == 0) begin
      // noise
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) line_q.push_back(pick_lead());
    line_q.push_back(book.mode ? CH_DASH : CH_HASH);
    repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
    if (book.mode) begin
      for (int i = 0; i < book.eff_len(); i++) line_q.push_back(book.name_char(i));
      repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
      line_q.push_back(CH_COLON);
      repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
    end
    repeat ($urandom_range(0, 12)) begin
      do c = 8'($urandom_range(1, 255)); while (c == CH_LF);
      line_q.push_back(c);
    end
    line_q.push_back(($urandom_range(9) < 8) ? CH_LF : CH_NUL);
    if (kind == 1) begin
      // broken line
      pos = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(3))
        0: line_q[pos] = 8'($urandom_range(0, 255));
        1: line_q[pos] = CH_NUL;
        2: line_q[pos] = ($urandom_range(1)) ? CH_COLON : (book.mode ? CH_HASH : CH_DASH);
        default: line_q.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic play_line(input int restart_pct);
    foreach (line_q[i]) send_item(i == 0 || $urandom_range(99) < restart_pct, line_q[i]);
  endtask

  initial begin
    int kind;
    int seg_count;
    book = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // title mode after reset
    send_item(1'b0, "A");
    send_text(" #\377\200\n");
    send_text("x");
    send_item(1'b1, CH_NUL);
    send_text("#a");
    send_text("#b");
    send_item(1'b0, CH_NUL);
    drain();

    // field mode, name "ab"
    write_cfg(1'b1, 5'd2, 64'h6261, '0);
    send_text("-ab:v\n");
    send_text("-ax");
    send_text("-a");
    send_item(1'b0, CH_NUL);
    send_text("-abq");
    drain();

    for (int seg = 0; seg < 16; seg++) begin
      apply_setting(seg / 2);
      set_idling(seg % 4);
      seg_count = 0;
      while (seg_count < SEG_ITEMS) begin
        kind = $urandom_range(99);
        build_line(kind < 10 ? 0 : (kind < 30 ? 1 : 2));
        play_line(kind < 10 ? 25 : 2);
        seg_count += line_q.size();
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 2)) send_item(1'b0, 8'($urandom_range(0, 255)));
        end
      end
      drain();
    end

    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("PASS markdown_header_field_parser");
    end else begin
      $display("FAIL markdown_header_field_parser");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL markdown_header_field_parser");
    $finish;
  end

endmodule
